### rtl/bli_pkg.sv
// bli_pkg: shared types and constants for the bearing line intersection block
// cordic step table, fixed-point widths, trig rounding and status codes
// no dependencies
package bli_pkg;

    // status codes carried on the result tuser
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_PARALLEL = 2'd1,
        STAT_SAT      = 2'd2
    } t_status;

    localparam int CORDIC_STEPS = 24;
    localparam int XW           = 27;   // cordic x/y datapath, 24 fraction bits
    localparam int ZW           = 34;   // cordic angle, 2^-32 turn units
    localparam int TW           = 16;   // trig values, 14 fraction bits
    localparam int DW           = 30;   // divisor magnitude

    localparam logic signed [XW-1:0] CORDIC_GAIN = 27'sd10188014;
    localparam logic signed [TW-1:0] TRIG_ONE    = 16'sd16384;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // round 24 fraction bits to 14 and clamp to plus or minus one
    function automatic logic signed [TW-1:0] trig_round(input logic signed [XW-1:0] v);
        logic signed [XW:0] t;
        t = $signed({v[XW-1], v}) + $signed((XW+1)'(512));
        t = t >>> 10;
        if (t > $signed((XW+1)'(TRIG_ONE))) begin
            return TRIG_ONE;
        end else if (t < -$signed((XW+1)'(TRIG_ONE))) begin
            return -TRIG_ONE;
        end
        return t[TW-1:0];
    endfunction

endpackage

### rtl/bearing_line_intersection.sv
// bearing_line_intersection: crossing point of two bearing lines, fully pipelined
// depends on bli_pkg (cordic table, widths, trig rounding, status codes)
//
//  channel   | direction | beat content (low bit first)
//  ----------+-----------+---------------------------------------------------------
//  s_axis    | in        | tdata: first_x, first_y, first_angle, second_x,
//            |           |        second_y, second_angle, zero pad to bytes
//  m_axis    | out       | tdata: cross_x, cross_y, zero pad; tuser: status
//  cfg       | in        | wr_data: parallel_threshold, written when wr_en is high
//
// one beat in and one beat out per cycle sustained while the output is not stalled;
// the datapath runs through the two 24-step cordic pipelines and the COORD_BITS-stage
// restoring dividers (one quotient bit per stage)
// reset is synchronous, active low; it clears valid bits and sets the threshold to 1
// a stalled output freezes the whole pipeline, so nothing is lost or repeated
module bearing_line_intersection
    import bli_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // first_x, first_y, first_angle, second_x, second_y, second_angle, pad
    input  logic [((4*COORD_BITS+2*ANGLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // cross_x, cross_y, pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output logic [1:0] o_m_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    input  logic i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data
);

    localparam int CW     = COORD_BITS;
    localparam int AB     = ANGLE_BITS;
    localparam int OUT_W  = ((2*CW+7)/8)*8;
    localparam int KW     = CW + 16;        // c_i terms
    localparam int PW     = KW + TW;        // numerator products and differences
    localparam int NW     = CW + 30;        // numerator magnitude plus half divisor
    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

    // global advance: everything moves unless a finished beat is held at the output
    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    logic [11:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 12'd1;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // ---------------- input unpack and angle folding ----------------
    logic signed [CW-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [AB-1:0]        w_a1, w_a2, w_d;
    logic [AB-2:0]        w_h;
    logic [AB-1:0]        w_hc, w_fold;
    logic [31:0]          w_t1, w_t2;
    logic                 n_f1, n_f2, n_par;
    logic signed [ZW-1:0] n_z1, n_z2;

    assign w_x1 = i_s_axis_tdata[CW-1:0];
    assign w_y1 = i_s_axis_tdata[2*CW-1:CW];
    assign w_a1 = i_s_axis_tdata[2*CW+AB-1:2*CW];
    assign w_x2 = i_s_axis_tdata[3*CW+AB-1:2*CW+AB];
    assign w_y2 = i_s_axis_tdata[4*CW+AB-1:3*CW+AB];
    assign w_a2 = i_s_axis_tdata[4*CW+2*AB-1:4*CW+AB];

    always_comb begin
        // angle scaled to a 32-bit turn; the left half plane is turned by half a turn
        w_t1 = 32'(w_a1) << (32 - AB);
        w_t2 = 32'(w_a2) << (32 - AB);
        n_f1 = w_t1[31] ^ w_t1[30];
        n_f2 = w_t2[31] ^ w_t2[30];
        n_z1 = ZW'($signed({w_t1[31] ^ n_f1, w_t1[30:0]}));
        n_z2 = ZW'($signed({w_t2[31] ^ n_f2, w_t2[30:0]}));
        // folded angle difference, covers equal and opposite bearings
        w_d    = w_a1 - w_a2;
        w_h    = w_d[AB-2:0];
        w_hc   = {1'b1, {(AB-1){1'b0}}} - {1'b0, w_h};
        w_fold = ({1'b0, w_h} < w_hc) ? {1'b0, w_h} : w_hc;
        n_par  = 32'(w_fold) < 32'(r_thr);
    end

    // ---------------- cordic pipelines, both bearings side by side ----------------
    logic                 r_cv  [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_cx1 [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_cy1 [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_cz1 [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_cx2 [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_cy2 [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_cz2 [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_px1 [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_py1 [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_px2 [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_py2 [0:CORDIC_STEPS];
    logic                 r_pf1 [0:CORDIC_STEPS];
    logic                 r_pf2 [0:CORDIC_STEPS];
    logic                 r_pp  [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_en) begin
            r_cv[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx1[0] <= CORDIC_GAIN;
            r_cy1[0] <= '0;
            r_cz1[0] <= n_z1;
            r_cx2[0] <= CORDIC_GAIN;
            r_cy2[0] <= '0;
            r_cz2[0] <= n_z2;
            r_px1[0] <= w_x1;
            r_py1[0] <= w_y1;
            r_px2[0] <= w_x2;
            r_py2[0] <= w_y2;
            r_pf1[0] <= n_f1;
            r_pf2[0] <= n_f2;
            r_pp[0]  <= n_par;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] STEP = $signed({2'b00, ATAN_TURN[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (w_en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                // rotate toward zero residual angle
                if (!r_cz1[i][ZW-1]) begin
                    r_cx1[i+1] <= r_cx1[i] - (r_cy1[i] >>> i);
                    r_cy1[i+1] <= r_cy1[i] + (r_cx1[i] >>> i);
                    r_cz1[i+1] <= r_cz1[i] - STEP;
                end else begin
                    r_cx1[i+1] <= r_cx1[i] + (r_cy1[i] >>> i);
                    r_cy1[i+1] <= r_cy1[i] - (r_cx1[i] >>> i);
                    r_cz1[i+1] <= r_cz1[i] + STEP;
                end
                if (!r_cz2[i][ZW-1]) begin
                    r_cx2[i+1] <= r_cx2[i] - (r_cy2[i] >>> i);
                    r_cy2[i+1] <= r_cy2[i] + (r_cx2[i] >>> i);
                    r_cz2[i+1] <= r_cz2[i] - STEP;
                end else begin
                    r_cx2[i+1] <= r_cx2[i] + (r_cy2[i] >>> i);
                    r_cy2[i+1] <= r_cy2[i] - (r_cx2[i] >>> i);
                    r_cz2[i+1] <= r_cz2[i] + STEP;
                end
                r_px1[i+1] <= r_px1[i];
                r_py1[i+1] <= r_py1[i];
                r_px2[i+1] <= r_px2[i];
                r_py2[i+1] <= r_py2[i];
                r_pf1[i+1] <= r_pf1[i];
                r_pf2[i+1] <= r_pf2[i];
                r_pp[i+1]  <= r_pp[i];
            end
        end
    end

    // ---------------- undo the half-turn and round to 14 fraction bits ----------------
    logic                 r_tv;
    logic signed [TW-1:0] r_s1, r_c1, r_s2, r_c2;
    logic signed [CW-1:0] r_tx1, r_ty1, r_tx2, r_ty2;
    logic                 r_tp;
    logic signed [XW-1:0] n_xc1, n_ys1, n_xc2, n_ys2;

    always_comb begin
        n_xc1 = r_pf1[CORDIC_STEPS] ? -r_cx1[CORDIC_STEPS] : r_cx1[CORDIC_STEPS];
        n_ys1 = r_pf1[CORDIC_STEPS] ? -r_cy1[CORDIC_STEPS] : r_cy1[CORDIC_STEPS];
        n_xc2 = r_pf2[CORDIC_STEPS] ? -r_cx2[CORDIC_STEPS] : r_cx2[CORDIC_STEPS];
        n_ys2 = r_pf2[CORDIC_STEPS] ? -r_cy2[CORDIC_STEPS] : r_cy2[CORDIC_STEPS];
    end

    // ---------------- products and differences ----------------
    logic                    r_m1v, r_m2v, r_m3v, r_m4v;
    logic signed [CW+TW-1:0] r_xs1, r_yc1, r_xs2, r_yc2;
    logic signed [2*TW-1:0]  r_sc, r_cs;
    logic signed [TW-1:0]    r_m1s1, r_m1c1, r_m1s2, r_m1c2;
    logic                    r_m1p;
    logic signed [KW-1:0]    r_k1, r_k2;
    logic signed [2*TW:0]    r_den2;
    logic signed [TW-1:0]    r_m2s1, r_m2c1, r_m2s2, r_m2c2;
    logic                    r_m2p;
    logic signed [PW-1:0]    r_kc2, r_kc1, r_ks2, r_ks1;
    logic signed [2*TW:0]    r_den3;
    logic                    r_m3p;
    logic signed [PW-1:0]    r_nx, r_ny;
    logic signed [2*TW:0]    r_den4;
    logic                    r_m4p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv  <= 1'b0;
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
            r_m3v <= 1'b0;
            r_m4v <= 1'b0;
        end else if (w_en) begin
            r_tv  <= r_cv[CORDIC_STEPS];
            r_m1v <= r_tv;
            r_m2v <= r_m1v;
            r_m3v <= r_m2v;
            r_m4v <= r_m3v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1  <= trig_round(n_xc1);
            r_s1  <= trig_round(n_ys1);
            r_c2  <= trig_round(n_xc2);
            r_s2  <= trig_round(n_ys2);
            r_tx1 <= r_px1[CORDIC_STEPS];
            r_ty1 <= r_py1[CORDIC_STEPS];
            r_tx2 <= r_px2[CORDIC_STEPS];
            r_ty2 <= r_py2[CORDIC_STEPS];
            r_tp  <= r_pp[CORDIC_STEPS];
            // first products: anchor terms and the determinant terms
            r_xs1  <= r_tx1 * r_s1;
            r_yc1  <= r_ty1 * r_c1;
            r_xs2  <= r_tx2 * r_s2;
            r_yc2  <= r_ty2 * r_c2;
            r_sc   <= r_s1 * r_c2;
            r_cs   <= r_c1 * r_s2;
            r_m1s1 <= r_s1;
            r_m1c1 <= r_c1;
            r_m1s2 <= r_s2;
            r_m1c2 <= r_c2;
            r_m1p  <= r_tp;
            // line offsets c_i and the determinant
            r_k1   <= KW'(r_xs1) - KW'(r_yc1);
            r_k2   <= KW'(r_xs2) - KW'(r_yc2);
            r_den2 <= (2*TW+1)'(r_sc) - (2*TW+1)'(r_cs);
            r_m2s1 <= r_m1s1;
            r_m2c1 <= r_m1c1;
            r_m2s2 <= r_m1s2;
            r_m2c2 <= r_m1c2;
            r_m2p  <= r_m1p;
            // numerator products
            r_kc2  <= r_k1 * r_m2c2;
            r_kc1  <= r_k2 * r_m2c1;
            r_ks2  <= r_k1 * r_m2s2;
            r_ks1  <= r_k2 * r_m2s1;
            r_den3 <= r_den2;
            r_m3p  <= r_m2p || (r_den2 == '0);
            r_nx   <= r_kc2 - r_kc1;
            r_ny   <= r_ks2 - r_ks1;
            r_den4 <= r_den3;
            r_m4p  <= r_m3p;
        end
    end

    // ---------------- divider setup: magnitudes, rounding bias, range check ----------------
    logic [PW-1:0] w_anx, w_any;
    logic [2*TW:0] w_aden;
    logic [DW-1:0] n_dm;
    logic [NW-1:0] n_mx, n_my;
    always_comb begin
        w_anx  = r_nx[PW-1] ? PW'(-r_nx) : PW'(r_nx);
        w_any  = r_ny[PW-1] ? PW'(-r_ny) : PW'(r_ny);
        w_aden = r_den4[2*TW] ? (2*TW+1)'(-r_den4) : (2*TW+1)'(r_den4);
        n_dm   = w_aden[DW-1:0];
        // add half the divisor so that the truncating divide rounds half away
        n_mx   = NW'(w_anx) + NW'(n_dm >> 1);
        n_my   = NW'(w_any) + NW'(n_dm >> 1);
    end

    logic          r_dv   [0:CW];
    logic [DW-1:0] r_dd   [0:CW];
    logic [NW-1:0] r_dnx  [0:CW];
    logic [NW-1:0] r_dny  [0:CW];
    logic [DW-1:0] r_drx  [0:CW];
    logic [DW-1:0] r_dry  [0:CW];
    logic [CW-1:0] r_dqx  [0:CW];
    logic [CW-1:0] r_dqy  [0:CW];
    logic          r_dsx  [0:CW];
    logic          r_dsy  [0:CW];
    logic          r_dox  [0:CW];
    logic          r_doy  [0:CW];
    logic          r_dp   [0:CW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= r_m4v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dd[0]  <= n_dm;
            r_dnx[0] <= n_mx;
            r_dny[0] <= n_my;
            // upper part already holds the divisor: quotient too big for the field
            r_dox[0] <= n_mx[NW-1:CW] >= n_dm;
            r_doy[0] <= n_my[NW-1:CW] >= n_dm;
            r_drx[0] <= n_mx[NW-1:CW];
            r_dry[0] <= n_my[NW-1:CW];
            r_dqx[0] <= '0;
            r_dqy[0] <= '0;
            r_dsx[0] <= r_nx[PW-1] ^ r_den4[2*TW];
            r_dsy[0] <= r_ny[PW-1] ^ r_den4[2*TW];
            r_dp[0]  <= r_m4p;
        end
    end

    // restoring division, one quotient bit per stage, both coordinates in lockstep
    for (genvar k = 0; k < CW; k++) begin : g_div
        logic [DW:0] w_trx, w_try;
        logic        w_gx, w_gy;
        assign w_trx = {r_drx[k], r_dnx[k][CW-1-k]};
        assign w_try = {r_dry[k], r_dny[k][CW-1-k]};
        assign w_gx  = w_trx >= {1'b0, r_dd[k]};
        assign w_gy  = w_try >= {1'b0, r_dd[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_drx[k+1] <= w_gx ? DW'(w_trx - {1'b0, r_dd[k]}) : DW'(w_trx);
                r_dry[k+1] <= w_gy ? DW'(w_try - {1'b0, r_dd[k]}) : DW'(w_try);
                r_dqx[k+1] <= {r_dqx[k][CW-2:0], w_gx};
                r_dqy[k+1] <= {r_dqy[k][CW-2:0], w_gy};
                r_dd[k+1]  <= r_dd[k];
                r_dnx[k+1] <= r_dnx[k];
                r_dny[k+1] <= r_dny[k];
                r_dsx[k+1] <= r_dsx[k];
                r_dsy[k+1] <= r_dsy[k];
                r_dox[k+1] <= r_dox[k];
                r_doy[k+1] <= r_doy[k];
                r_dp[k+1]  <= r_dp[k];
            end
        end
    end

    // ---------------- sign, saturation, status and output register ----------------
    logic [CW-1:0] n_rx, n_ry;
    logic          n_satx, n_saty;
    t_status       n_stat;

    always_comb begin
        n_satx = r_dox[CW] || (r_dsx[CW] ? (r_dqx[CW] > NEG_MIN) : (r_dqx[CW] > POS_MAX));
        n_saty = r_doy[CW] || (r_dsy[CW] ? (r_dqy[CW] > NEG_MIN) : (r_dqy[CW] > POS_MAX));
        if (n_satx) begin
            n_rx = r_dsx[CW] ? NEG_MIN : POS_MAX;
        end else begin
            n_rx = r_dsx[CW] ? CW'(-r_dqx[CW]) : r_dqx[CW];
        end
        if (n_saty) begin
            n_ry = r_dsy[CW] ? NEG_MIN : POS_MAX;
        end else begin
            n_ry = r_dsy[CW] ? CW'(-r_dqy[CW]) : r_dqy[CW];
        end
        n_stat = (n_satx || n_saty) ? STAT_SAT : STAT_OK;
        if (r_dp[CW]) begin
            n_rx   = '0;
            n_ry   = '0;
            n_stat = STAT_PARALLEL;
        end
    end

    logic          r_ov;
    logic [CW-1:0] r_ox, r_oy;
    t_status       r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_dv[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox    <= n_rx;
            r_oy    <= n_ry;
            r_ostat <= n_stat;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OUT_W'({r_oy, r_ox});
    assign o_m_axis_tuser  = r_ostat;

    // ---------------- checks ----------------
    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == STAT_PARALLEL) |-> (r_ox == '0 && r_oy == '0))
        else $error("parallel result with nonzero coordinates");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == STAT_SAT) |->
        (r_ox == POS_MAX || r_ox == NEG_MIN || r_oy == POS_MAX || r_oy == NEG_MIN))
        else $error("saturated status without a clamped coordinate");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_dv[CW]) && $stable(r_cv[0]))
        else $error("pipeline moved while the output was stalled");

endmodule

### verif/bearing_line_intersection_tb.sv
// bearing_line_intersection_tb: self-checking bench for the bearing line intersection block
// integer predictor with cordic trig; directed corners then random anchor pairs
// depends on bli_pkg and the bearing_line_intersection rtl
module bearing_line_intersection_tb;
    import bli_pkg::*;

    localparam int AB = 16;
    localparam int CB = 24;
    localparam int IW = 128;   // input tdata width
    localparam int OW = 48;    // output tdata width
    localparam int LAT = CB + 31;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        t_status st;
    } t_cross;

    // integer model of the intersection, one queue of expected crossings
    class cross_board;
        t_cross pending[$];
        logic [11:0] thresh;
        int errors;

        function new();
            thresh = 12'd1;
            errors = 0;
        endfunction

        static function longint fshift(longint v, int n);
            return v >>> n;
        endfunction

        static function void trig(logic [AB-1:0] ang, output longint s, output longint c);
            longint x, y, z, nx, t;
            logic [31:0] a;
            bit flip;
            a = {ang, 16'd0};
            flip = 0;
            if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
                a = a - 32'h8000_0000;
                flip = 1;
            end
            z = longint'($signed(a));
            x = 10188014;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - fshift(y, i);
                    y = y + fshift(x, i);
                    z = z - longint'(ATAN_TURN[i]);
                end else begin
                    nx = x + fshift(y, i);
                    y = y - fshift(x, i);
                    z = z + longint'(ATAN_TURN[i]);
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            t = fshift(x + 512, 10);
            c = t > 16384 ? 16384 : (t < -16384 ? -16384 : t);
            t = fshift(y + 512, 10);
            s = t > 16384 ? 16384 : (t < -16384 ? -16384 : t);
        endfunction

        static function longint rdiv(longint n, longint d);
            longint un, ud, q;
            un = n < 0 ? -n : n;
            ud = d < 0 ? -d : d;
            q = (un + ud / 2) / ud;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        static function longint clampc(longint v, ref bit sat);
            if (v > 8388607) begin
                sat = 1;
                return 8388607;
            end
            if (v < -8388608) begin
                sat = 1;
                return -8388608;
            end
            return v;
        endfunction

        function void note_pair(logic [IW-1:0] d);
            longint x1, y1, x2, y2, s1, c1, s2, c2, den, k1, k2, rx, ry;
            logic [AB-1:0] a1, a2, h, fold;
            bit sat;
            t_cross r;
            x1 = longint'($signed(d[23:0]));
            y1 = longint'($signed(d[47:24]));
            a1 = d[63:48];
            x2 = longint'($signed(d[87:64]));
            y2 = longint'($signed(d[111:88]));
            a2 = d[127:112];
            h = (a1 - a2) & 16'h7fff;
            fold = (h < 16'h8000 - h) ? h : 16'h8000 - h;
            trig(a1, s1, c1);
            trig(a2, s2, c2);
            den = s1 * c2 - c1 * s2;
            sat = 0;
            if (fold < {4'd0, thresh} || den == 0) begin
                r = '{x: '0, y: '0, st: STAT_PARALLEL};
            end else begin
                k1 = x1 * s1 - y1 * c1;
                k2 = x2 * s2 - y2 * c2;
                rx = clampc(rdiv(k1 * c2 - k2 * c1, den), sat);
                ry = clampc(rdiv(k1 * s2 - k2 * s1, den), sat);
                r.x = rx[CB-1:0];
                r.y = ry[CB-1:0];
                r.st = sat ? STAT_SAT : STAT_OK;
            end
            pending.push_back(r);
        endfunction

        function void check_cross(logic [OW-1:0] d, logic [1:0] st);
            t_cross e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result x=%0d y=%0d st=%0d", $time,
                         $signed(d[23:0]), $signed(d[47:24]), st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.x !== d[23:0]) begin
                $display("%0t cross_x exp %0d got %0d", $time, e.x, $signed(d[23:0]));
                errors++;
            end
            if (e.y !== d[47:24]) begin
                $display("%0t cross_y exp %0d got %0d", $time, e.y, $signed(d[47:24]));
                errors++;
            end
            if (e.st !== st) begin
                $display("%0t status exp %0d got %0d", $time, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic [IW-1:0] i_s_axis_tdata = '0;
    logic i_s_axis_tvalid = 0;
    logic o_s_axis_tready;
    logic [OW-1:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 0;
    logic i_cfg_wr_en = 0;
    logic [11:0] i_cfg_wr_data = '0;

    cross_board board = new();
    int send_idle_pct = 0;     // sender idle chance in percent
    int recv_idle_pct = 0;     // receiver stall chance in percent
    int hold_off = 0;          // cycles left in a long receiver stall

    bearing_line_intersection dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // receiver: random stalls, plus the long hold-off when asked
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready && i_rst_n) begin
            board.check_cross(o_m_axis_tdata, o_m_axis_tuser);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // a coordinate with a bias toward the extremes
    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2, 3: return 24'($urandom);
            default: return 24'($signed($urandom_range(20000)) - 10000) <<< 8;
        endcase
    endfunction

    // one beat, waits for acceptance; random gaps before it
    task automatic send_pair(logic [CB-1:0] x1, logic [CB-1:0] y1, logic [AB-1:0] a1,
                             logic [CB-1:0] x2, logic [CB-1:0] y2, logic [AB-1:0] a2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_axis_tdata <= {a2, y2, x2, a1, y1, x1};
        i_s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_pair({a2, y2, x2, a1, y1, x1});
    endtask

    task automatic random_pair();
        logic [AB-1:0] a1, a2;
        a1 = 16'($urandom);
        case ($urandom_range(7))
            0: a2 = a1 + 16'($urandom_range(8)) - 16'd4;            // near parallel
            1: a2 = a1 + 16'h8000 + 16'($urandom_range(8)) - 16'd4; // near opposite
            default: a2 = 16'($urandom);
        endcase
        send_pair(rand_coord(), rand_coord(), a1, rand_coord(), rand_coord(), a2);
    endtask

    // drain then write the threshold while idle
    task automatic set_thresh(logic [11:0] v);
        i_s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        board.thresh = v;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset threshold, exact and opposite bearings, axes, extremes
        send_pair(0, 0, 16'h0000, 24'd256, 0, 16'h4000);
        send_pair(0, 0, 16'h1234, 24'd2560, 24'd512, 16'h1234);
        send_pair(0, 0, 16'h1000, 24'd2560, 24'd512, 16'h9000);
        send_pair(0, 0, 16'h2000, 24'd100, 24'd7, 16'h2001);
        send_pair(24'h7fffff, 24'h7fffff, 16'h0000, 24'h800000, 24'h800000, 16'h4000);
        send_pair(24'h800000, 24'h7fffff, 16'hffff, 24'h7fffff, 24'h800000, 16'h8000);
        send_pair(0, 0, 16'h0001, 24'h7fffff, 0, 16'h8002);
        send_pair(24'd256, 24'd256, 16'h4000, 24'hffff00, 24'hffff00, 16'hc000);
        send_pair(24'hffffff, 24'h000001, 16'h6000, 24'h123456, 24'hedcba9, 16'h2000);
        send_pair(24'h555555, 24'haaaaaa, 16'h5555, 24'haaaaaa, 24'h555555, 16'haaaa);
        send_pair(0, 0, 16'h0000, 0, 0, 16'h7fff);
        set_thresh(12'd0);
        send_pair(0, 0, 16'h1234, 24'd2560, 24'd512, 16'h1234);
        send_pair(0, 0, 16'h0000, 24'd2560, 24'd512, 16'h0001);
        set_thresh(12'hfff);
        send_pair(0, 0, 16'h0000, 24'd2560, 24'd512, 16'h4000);
        send_pair(0, 0, 16'h0000, 24'd2560, 24'd512, 16'h1000);
        set_thresh(12'd16);

        // long receiver stall while the sender keeps offering beats
        hold_off = 300;
        for (int i = 0; i < 150; i++) random_pair();

        send_idle_pct = 30;
        recv_idle_pct = 69;
        for (int i = 0; i < 600; i++) random_pair();
        set_thresh(12'($urandom));
        send_idle_pct = 69;
        recv_idle_pct = 30;
        for (int i = 0; i < 600; i++) random_pair();
        set_thresh(12'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 600; i++) random_pair();
        i_s_axis_tvalid <= 0;

        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### bearing_line_intersection.f
rtl/bli_pkg.sv
rtl/bearing_line_intersection.sv
verif/bearing_line_intersection_tb.sv
